// ===== hw/rtl/stepper_pulse_generator_ramp_unit_assert.svh =====
// Assertion macros shared by the checker of the stepper pulse generator.
`ifndef STEPPER_PULSE_GENERATOR_RAMP_UNIT_ASSERT_SVH
`define STEPPER_PULSE_GENERATOR_RAMP_UNIT_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define SPG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define SPG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/spg_pkg.sv =====
// Shared widths, codes and types of the stepper pulse generator.
package spg_pkg;

  // Width of the signed count of steps still to be issued.
  localparam int COUNT_WIDTH = 24;

  localparam int TIME_W     = 16;
  localparam int RAMP_W     = 8;
  localparam int DELAY_W    = 24;
  localparam int ELAPSED_W  = 25;
  localparam int POS_W      = 32;
  localparam int STEPS_W    = 16;
  localparam int LEFT_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = 33;

  // Saturation bounds of the step count, sign-extended to the sum width.
  localparam logic signed [SUM_W-1:0] CNT_MAX =
    $signed({{(SUM_W-COUNT_WIDTH+1){1'b0}}, {(COUNT_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] CNT_MIN = ~CNT_MAX;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Pulse phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DELAY = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] low_time;
    logic [TIME_W-1:0] high_time;
    logic [RAMP_W-1:0] ramp_width;
    logic [TIME_W-1:0] ramp_delay;
  } spg_cfg_t;

  typedef struct packed {
    logic [1:0]                     phase;
    logic [ELAPSED_W-1:0]           elapsed;
    logic [DELAY_W-1:0]             delay;
    logic signed [COUNT_WIDTH-1:0]  remaining;
    logic [RAMP_W-1:0]              ramp_count;
    logic [POS_W-1:0]               total;
  } spg_state_t;

endpackage

// ===== hw/rtl/spg_if.sv =====
// Valid/ready channel interfaces for input requests and result requests.
interface spg_in_if;
  import spg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [STEPS_W-1:0] steps;

  modport source (output valid, output mode, output steps, input ready);
  modport sink   (input valid, input mode, input steps, output ready);
endinterface

interface spg_out_if;
  import spg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     step_level;
  logic                     direction;
  logic signed [LEFT_W-1:0] steps_left;
  logic signed [POS_W-1:0]  position;
  logic                     busy_res;

  modport source (output valid, output step_level, output direction, output steps_left,
                  output position, output busy_res, input ready);
  modport sink   (input valid, input step_level, input direction, input steps_left,
                  input position, input busy_res, output ready);
endinterface

// ===== hw/rtl/stepper_pulse_generator_ramp_unit.sv =====
// Top level of the stepper step/direction pulse generator with speed ramp.
// The result of an accepted request is loaded into the output register in the next cycle.
// Throughput: one request per cycle while the output is not stalled; the pulse state updates in a single pass.
// A request is taken while the output register is empty or is being drained.
// Reset (synchronous, active low) clears the pulse state and output valid, and
// loads the registers with low 1000, high 750, ramp width 10 and ramp delay 100.
module stepper_pulse_generator_ramp_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  spg_in_if.sink                             in_ch,
  spg_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [spg_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [spg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import spg_pkg::*;

  spg_cfg_t             cfg_r;
  spg_state_t           state_r;
  spg_state_t           state_nxt;
  logic                 out_valid_r;
  logic                 step_level_r;
  logic                 direction_r;
  logic signed [LEFT_W-1:0] steps_left_r;
  logic signed [POS_W-1:0]  position_r;
  logic                 busy_r;
  logic                 in_acc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_time   <= TIME_W'(1000);
      cfg_r.high_time  <= TIME_W'(750);
      cfg_r.ramp_width <= RAMP_W'(10);
      cfg_r.ramp_delay <= TIME_W'(100);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LOW_TIME:   cfg_r.low_time   <= cfg_data[TIME_W-1:0];
        REG_HIGH_TIME:  cfg_r.high_time  <= cfg_data[TIME_W-1:0];
        REG_RAMP_WIDTH: cfg_r.ramp_width <= cfg_data[RAMP_W-1:0];
        REG_RAMP_DELAY: cfg_r.ramp_delay <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  spg_step u_step (
    .cfg_i     (cfg_r),
    .state_i   (state_r),
    .mode_i    (in_ch.mode),
    .steps_i   (in_ch.steps),
    .state_nxt (state_nxt)
  );

  // Pulse state advances on each accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload shows the state after the request.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      step_level_r <= (state_nxt.phase == PH_HIGH);
      direction_r  <= !state_nxt.remaining[COUNT_WIDTH-1] && (state_nxt.remaining != '0);
      steps_left_r <= LEFT_W'($signed(state_nxt.remaining));
      position_r   <= $signed(state_nxt.total);
      busy_r       <= (state_nxt.remaining != '0);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.step_level = step_level_r;
  assign out_ch.direction  = direction_r;
  assign out_ch.steps_left = steps_left_r;
  assign out_ch.position   = position_r;
  assign out_ch.busy_res   = busy_r;

endmodule

// ===== hw/rtl/spg_step.sv =====
// Next-state logic of the pulse generator for one tick or add-steps request.
module spg_step (
  input  spg_pkg::spg_cfg_t                cfg_i,
  input  spg_pkg::spg_state_t              state_i,
  input  logic                             mode_i,
  input  logic signed [spg_pkg::STEPS_W-1:0] steps_i,
  output spg_pkg::spg_state_t              state_nxt
);
  import spg_pkg::*;

  logic [COUNT_WIDTH-1:0]  rem_u;
  logic [COUNT_WIDTH-1:0]  left;
  logic                    near_end;
  logic [RAMP_W-1:0]       factor;
  logic [DELAY_W-1:0]      delay_new;
  logic signed [SUM_W-1:0] sum;

  // Magnitude of the remaining count and the delay for a pulse that starts now.
  // Inside the ramp width the deceleration factor always wins over the ramp count.
  assign rem_u     = state_i.remaining;
  assign left      = rem_u[COUNT_WIDTH-1] ? (~rem_u + 1'b1) : rem_u;
  assign near_end  = left < COUNT_WIDTH'(cfg_i.ramp_width);
  assign factor    = near_end ? (cfg_i.ramp_width - left[RAMP_W-1:0]) : state_i.ramp_count;
  assign delay_new = DELAY_W'(factor) * DELAY_W'(cfg_i.ramp_delay);

  // Saturating sum for an add-steps request.
  assign sum = SUM_W'($signed(state_i.remaining)) + SUM_W'(steps_i);

  always_comb begin
    state_nxt = state_i;
    if (mode_i) begin
      if (sum > CNT_MAX) begin
        state_nxt.remaining = CNT_MAX[COUNT_WIDTH-1:0];
      end else if (sum < CNT_MIN) begin
        state_nxt.remaining = CNT_MIN[COUNT_WIDTH-1:0];
      end else begin
        state_nxt.remaining = sum[COUNT_WIDTH-1:0];
      end
      state_nxt.ramp_count = cfg_i.ramp_width;
    end else if (state_i.remaining == '0) begin
      // Nothing left to issue: drop any pulse in progress.
      state_nxt.phase   = PH_IDLE;
      state_nxt.elapsed = '0;
    end else begin
      // Start a pulse or advance the phase timer.
      if (state_i.phase == PH_IDLE) begin
        state_nxt.delay   = delay_new;
        state_nxt.phase   = PH_HIGH;
        state_nxt.elapsed = '0;
      end else if (state_i.elapsed != ELAPSED_MAX) begin
        state_nxt.elapsed = state_i.elapsed + 1'b1;
      end
      // End of the high phase.
      if (state_nxt.phase == PH_HIGH &&
          state_nxt.elapsed >= ELAPSED_W'(cfg_i.high_time) + ELAPSED_W'(state_nxt.delay)) begin
        if (state_nxt.ramp_count != '0) begin
          state_nxt.ramp_count = state_nxt.ramp_count - 1'b1;
        end
        state_nxt.phase   = PH_LOW;
        state_nxt.elapsed = '0;
      end
      // End of the low phase completes one step.
      if (state_nxt.phase == PH_LOW &&
          state_nxt.elapsed >= ELAPSED_W'(cfg_i.low_time) + ELAPSED_W'(state_nxt.delay)) begin
        state_nxt.phase   = PH_IDLE;
        state_nxt.elapsed = '0;
        if (!rem_u[COUNT_WIDTH-1]) begin
          state_nxt.remaining = state_i.remaining - 1'b1;
          state_nxt.total     = state_i.total - 1'b1;
        end else begin
          state_nxt.remaining = state_i.remaining + 1'b1;
          state_nxt.total     = state_i.total + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/spg_checker.sv =====
// Port-level checker of the pulse generator and its bind to the top level.
`include "stepper_pulse_generator_ramp_unit_assert.svh"

module spg_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_direction,
  input logic                               out_busy_res,
  input logic signed [spg_pkg::POS_W-1:0]   out_position
);
  import spg_pkg::*;

  logic signed [POS_W-1:0] last_pos_r;
  logic                    have_r;
  logic signed [POS_W-1:0] pos_delta;

  // Remember the position of the last delivered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_pos_r <= out_position;
    end
  end

  assign pos_delta = out_position - last_pos_r;

  // A stalled result stays offered.
  `SPG_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  // Reset empties the output register.
  `SPG_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid after reset")
  // An empty output register always takes a new request.
  `SPG_ASSERT(a_ready_empty, clk, rst_n, !out_valid |-> in_ready, "not ready with empty output")
  // Forward direction only while steps remain.
  `SPG_ASSERT(a_dir_busy, clk, rst_n, out_valid && out_direction |-> out_busy_res, "direction without busy")
  // Each request moves the position by at most one step.
  `SPG_ASSERT(a_pos_step, clk, rst_n, out_valid && out_ready && have_r |-> pos_delta == 0 || pos_delta == 1 || pos_delta == -1, "position jumped")

endmodule

bind stepper_pulse_generator_ramp_unit spg_checker u_spg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_direction (out_ch.direction),
  .out_busy_res  (out_ch.busy_res),
  .out_position  (out_ch.position)
);
